FILE: rtl/core/bbng_pkg.sv
`timescale 1ns / 1ps
package bbng_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 24;

	localparam int unsigned DIGIT_BITS = 4;
	localparam int unsigned LCG_DIGITS = 8;
	localparam int unsigned LVL_DIGITS = 4;
	localparam int unsigned CNT_BITS   = 3;

	localparam int unsigned BROWN_BITS = 27;
	localparam int unsigned WHITE_BITS = 23;
	localparam int unsigned LEVEL_BITS = 16;
	localparam int unsigned PROD_BITS  = WHITE_BITS + LEVEL_BITS;

	localparam logic [31:0] LCG_MUL  = 32'd196314165;
	localparam logic [31:0] LCG_ADD  = 32'd907633515;
	localparam logic [31:0] LCG_SEED = 32'd66666666;

	localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 16'd4915;

	localparam logic signed [BROWN_BITS:0] BROWN_HI = 28'sd33554432;
	localparam logic signed [BROWN_BITS:0] BROWN_LO = -28'sd33554432;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG,
		ST_MUL,
		ST_CHECK,
		ST_FINISH
	} state_t;

endpackage

FILE: rtl/core/bbng_cfg_if.sv
`timescale 1ns / 1ps
interface bbng_cfg_if;
	import bbng_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] step_scale;

	modport source (output valid, output step_scale, input ready);
	modport sink (input valid, input step_scale, output ready);

endinterface

FILE: rtl/core/bbng_in_if.sv
`timescale 1ns / 1ps
interface bbng_in_if #(
	parameter int unsigned SAMPLE_BITS = bbng_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic                          new_frame;
	logic signed [SAMPLE_BITS-1:0] in_sample;

	modport source (output valid, output opcode, output new_frame, output in_sample,
		input ready);
	modport sink (input valid, input opcode, input new_frame, input in_sample,
		output ready);

endinterface

FILE: rtl/core/bbng_out_if.sv
`timescale 1ns / 1ps
interface bbng_out_if #(
	parameter int unsigned SAMPLE_BITS = bbng_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);

endinterface

FILE: rtl/core/bounded_brown_noise_generator.sv
`timescale 1ns / 1ps
// Bounded brown noise source with an optional add-to-input mode.
// The cfg_ch channel sets the noise level; it is always ready and should only
// be written while no item is in flight.
// Each transfer on in_ch gives exactly one transfer on out_ch. With new_frame
// clear the held noise value is reused. With new_frame set a draw is made:
// the generator state is advanced by a 4-bit digit-serial multiply, the step
// is formed from it by a 4-bit digit-serial multiply by the noise level, and
// the new running total is then checked against the bound. Each draw that
// leaves the bound is retried, and only a draw inside it updates the total.
// in_ch is ready only while the datapath is idle; the result sits in an
// output register, so a new transfer may be taken while it waits.
// If the receiver stalls, the finished item waits in the last stage until the
// output register is free.
// Reset clears the running total and the held value, reloads the seed and the
// default noise level, and empties the output register.
module bounded_brown_noise_generator #(
	parameter int unsigned SAMPLE_BITS = bbng_pkg::SAMPLE_BITS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	bbng_cfg_if.sink       cfg_ch,
	bbng_in_if.sink        in_ch,
	bbng_out_if.source     out_ch
);
	import bbng_pkg::*;

	state_t state_q, state_d;

	logic [LEVEL_BITS-1:0]        level_q;
	logic [31:0]                  lcg_q;
	logic signed [BROWN_BITS-1:0] brown_q;
	logic signed [SAMPLE_BITS-1:0] held_q;

	logic                          op_q;
	logic signed [SAMPLE_BITS-1:0] in_q;

	logic [CNT_BITS-1:0] cnt_q;
	logic [31:0]         lcg_acc_q;
	logic [31:0]         seed_sh_q;
	logic [31:0]         mul_sh_q;

	logic signed [PROD_BITS-1:0] u_sh_q;
	logic signed [PROD_BITS-1:0] macc_q;
	logic [LEVEL_BITS-1:0]       lvl_sh_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;

	logic in_fire;
	logic load_lcg;
	logic fin_fire;

	logic [31:0]                   lcg_pp;
	logic [31:0]                   lcg_sum;
	logic signed [DIGIT_BITS:0]    lvl_digit;
	logic signed [PROD_BITS-1:0]   macc_sum;
	logic signed [WHITE_BITS-1:0]  step;
	logic signed [BROWN_BITS:0]    brown_next;
	logic                          in_range;
	logic [SAMPLE_BITS+BROWN_BITS-1:0] scaled;
	logic signed [SAMPLE_BITS:0]   add_sum;
	logic signed [SAMPLE_BITS-1:0] add_sat;
	logic signed [SAMPLE_BITS-1:0] result;

	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_fire      = in_ch.valid && (state_q == ST_IDLE);

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_sample = out_data_q;

	assign lcg_pp  = seed_sh_q * 32'(mul_sh_q[DIGIT_BITS-1:0]);
	assign lcg_sum = lcg_acc_q + lcg_pp;

	assign lvl_digit = signed'({1'b0, lvl_sh_q[DIGIT_BITS-1:0]});
	assign macc_sum  = macc_q + u_sh_q * lvl_digit;

	assign step       = macc_q[PROD_BITS-1:LEVEL_BITS];
	assign brown_next = (BROWN_BITS+1)'(brown_q) + (BROWN_BITS+1)'(step);
	assign in_range   = (brown_next >= BROWN_LO) && (brown_next <= BROWN_HI);
	assign scaled     = {brown_next[BROWN_BITS-1:0], {SAMPLE_BITS{1'b0}}};

	assign add_sum = (SAMPLE_BITS+1)'(in_q) + (SAMPLE_BITS+1)'(held_q);

	always_comb begin
		priority if (add_sum > (SAMPLE_BITS+1)'(SAT_MAX)) begin
			add_sat = SAT_MAX;
		end else if (add_sum < (SAMPLE_BITS+1)'(SAT_MIN)) begin
			add_sat = SAT_MIN;
		end else begin
			add_sat = add_sum[SAMPLE_BITS-1:0];
		end
	end

	assign result = op_q ? add_sat : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_lcg = 1'b0;
		fin_fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.new_frame) begin
						load_lcg = 1'b1;
						state_d  = ST_LCG;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_LCG: begin
				if (cnt_q == CNT_BITS'(LCG_DIGITS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == CNT_BITS'(LVL_DIGITS - 1)) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (in_range) begin
					state_d = ST_FINISH;
				end else begin
					load_lcg = 1'b1;
					state_d  = ST_LCG;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					fin_fire = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= LEVEL_RESET;
			lcg_q       <= LCG_SEED;
			brown_q     <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_ch.valid) begin
				level_q <= cfg_ch.step_scale;
			end
			if (load_lcg) begin
				cnt_q <= '0;
			end else if (state_q == ST_LCG && cnt_q == CNT_BITS'(LCG_DIGITS - 1)) begin
				cnt_q <= '0;
				lcg_q <= lcg_sum;
			end else if (state_q == ST_LCG || state_q == ST_MUL) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ST_CHECK && in_range) begin
				brown_q <= brown_next[BROWN_BITS-1:0];
				held_q  <= scaled[SAMPLE_BITS+BROWN_BITS-1:BROWN_BITS];
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= in_ch.opcode;
			in_q <= in_ch.in_sample;
		end
		if (load_lcg) begin
			lcg_acc_q <= LCG_ADD;
			seed_sh_q <= lcg_q;
			mul_sh_q  <= LCG_MUL;
		end else if (state_q == ST_LCG) begin
			lcg_acc_q <= lcg_sum;
			seed_sh_q <= seed_sh_q << DIGIT_BITS;
			mul_sh_q  <= mul_sh_q >> DIGIT_BITS;
		end
		if (state_q == ST_LCG && cnt_q == CNT_BITS'(LCG_DIGITS - 1)) begin
			u_sh_q   <= PROD_BITS'(signed'({~lcg_sum[31], lcg_sum[30:32-WHITE_BITS]}));
			lvl_sh_q <= level_q;
			macc_q   <= '0;
		end else if (state_q == ST_MUL) begin
			macc_q   <= macc_sum;
			u_sh_q   <= u_sh_q <<< DIGIT_BITS;
			lvl_sh_q <= lvl_sh_q >> DIGIT_BITS;
		end
		if (fin_fire) begin
			out_data_q <= result;
		end
	end

endmodule

FILE: rtl/core/bbng_checker.sv
`timescale 1ns / 1ps
module bbng_checker #(
	parameter int unsigned SAMPLE_BITS = bbng_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample
);

	// A stalled result keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again while busy");

	// A result cannot appear in the cycle after a transfer is taken.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	// A fresh result is presented only as the datapath goes idle.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result raised while datapath busy");

endmodule

bind bounded_brown_noise_generator bbng_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_bbng_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.out_sample)
);

FILE: verif/bounded_brown_noise_generator_tb.sv
`timescale 1ns / 1ps
module bounded_brown_noise_generator_tb;
	import bbng_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam logic [31:0] SEED_MUL = 32'd196314165;
	localparam logic [31:0] SEED_ADD = 32'd907633515;
	localparam logic [31:0] SEED_START = 32'd66666666;
	localparam logic [15:0] LEVEL_DEFAULT = 16'd4915;
	localparam longint WHITE_MID = 64'sd4194304;
	localparam longint TOTAL_BOUND = 64'sd33554432;
	localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	class noise_sample_checker;
		logic [31:0] seed;
		longint brown_total;
		longint held_noise;
		logic [15:0] level;
		logic signed [SB-1:0] expected_samples[$];
		int error_count;

		function new();
			seed = SEED_START;
			brown_total = 0;
			held_noise = 0;
			level = LEVEL_DEFAULT;
			error_count = 0;
		endfunction

		function void set_level(logic [15:0] value);
			level = value;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		function void note_input(logic opcode, logic new_frame,
			logic signed [SB-1:0] in_sample);
			longint white;
			longint step;
			longint next_total;
			longint sum;
			if (new_frame) begin
				do begin
					seed = seed * SEED_MUL + SEED_ADD;
					white = longint'(seed[31:9]) - WHITE_MID;
					step = (white * longint'(level)) >>> 16;
					next_total = brown_total + step;
				end while (next_total < -TOTAL_BOUND || next_total > TOTAL_BOUND);
				brown_total = next_total;
				held_noise = brown_total >>> (27 - SB);
			end
			if (opcode) begin
				sum = longint'(in_sample) + held_noise;
				if (sum > longint'(SAMPLE_MAX))
					sum = longint'(SAMPLE_MAX);
				if (sum < longint'(SAMPLE_MIN))
					sum = longint'(SAMPLE_MIN);
			end else begin
				sum = held_noise;
			end
			expected_samples.push_back(sum[SB-1:0]);
		endfunction

		function void check_sample(logic signed [SB-1:0] actual);
			logic signed [SB-1:0] wanted;
			if (expected_samples.size() == 0) begin
				$error("out_sample: expected nothing, got %0d", actual);
				error_count++;
			end else begin
				wanted = expected_samples.pop_front();
				if (actual !== wanted) begin
					$error("out_sample: expected %0d, got %0d", wanted, actual);
					error_count++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	noise_sample_checker sb = new();

	bbng_cfg_if cfg_ch();
	bbng_in_if #(.SAMPLE_BITS(SB)) in_ch();
	bbng_out_if #(.SAMPLE_BITS(SB)) out_ch();

	bounded_brown_noise_generator #(.SAMPLE_BITS(SB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_ch(cfg_ch),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_sample(out_ch.out_sample);
		out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
	end

	task automatic send_sample(logic opcode, logic new_frame,
		logic signed [SB-1:0] in_sample);
		if ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= opcode;
		in_ch.new_frame <= new_frame;
		in_ch.in_sample <= in_sample;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(opcode, new_frame, in_sample);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_level(logic [15:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.step_scale <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.set_level(value);
	endtask

	task automatic send_random(int count);
		logic signed [SB-1:0] smp;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: smp = SAMPLE_MAX;
				1: smp = SAMPLE_MIN;
				default: smp = SB'($urandom);
			endcase
			send_sample(1'($urandom_range(1)), $urandom_range(3) != 0, smp);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.step_scale <= '0;
		in_ch.valid <= 1'b0;
		in_ch.opcode <= 1'b0;
		in_ch.new_frame <= 1'b0;
		in_ch.in_sample <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(1'b0, 1'b0, '0);
		send_sample(1'b1, 1'b0, SAMPLE_MAX);
		send_sample(1'b1, 1'b0, SAMPLE_MIN);
		send_sample(1'b0, 1'b1, '0);
		send_sample(1'b1, 1'b0, 24'sh123456);
		send_sample(1'b1, 1'b1, SAMPLE_MAX);
		send_sample(1'b1, 1'b1, SAMPLE_MIN);
		send_sample(1'b1, 1'b1, -24'sd1);

		write_level(16'd0);
		send_sample(1'b0, 1'b1, '0);
		send_sample(1'b1, 1'b1, 24'sh5a5a5a);
		send_sample(1'b0, 1'b0, '0);

		write_level(16'hffff);
		for (int i = 0; i < 14; i++)
			send_sample(i[0], 1'b1, i[1] ? SAMPLE_MIN : SAMPLE_MAX);

		write_level(16'hffff);
		send_random(150);

		write_level(16'($urandom_range(65535)));
		in_idle_pct = 85;
		send_random(150);

		write_level(16'd1);
		in_idle_pct = 0;
		out_stall_pct = 85;
		send_random(150);

		write_level(16'($urandom_range(65535)));
		in_idle_pct = 27;
		out_stall_pct = 27;
		send_random(150);

		drain();
		repeat (20) @(posedge clk);
		if (sb.error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: bounded_brown_noise_generator.f
rtl/core/bbng_pkg.sv
rtl/core/bbng_cfg_if.sv
rtl/core/bbng_in_if.sv
rtl/core/bbng_out_if.sv
rtl/core/bounded_brown_noise_generator.sv
rtl/core/bbng_checker.sv
verif/bounded_brown_noise_generator_tb.sv
